>>> design/wav_hdr_pkg.sv
// ----------------------------------------------------------------------------
// wav_hdr_pkg
// Types, tags and codes shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;  // "RIFF", little-endian
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] TagData = 32'h6174_6164;  // "data"
  localparam logic [31:0] FmtBase = 32'd16;
  localparam logic [15:0] BitsNarrow = 16'd8;
  localparam logic [15:0] BitsWide   = 16'd16;
  localparam logic [15:0] PcmTag     = 16'd1;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_RIFF    = 3'd0,
    ERR_BAD_FMT     = 3'd1,
    ERR_NOT_PCM     = 3'd2,
    ERR_BAD_FORMAT  = 3'd3,
    ERR_TRUNC_HDR   = 3'd4,
    ERR_NO_DATA     = 3'd5,
    ERR_TRUNC_DATA  = 3'd6
  } err_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [31:0] data_length;
    logic [7:0]  audio_byte;
    logic        last_byte;
    logic [2:0]  error_code;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

>>> design/wav_hdr_in_if.sv
// ----------------------------------------------------------------------------
// wav_hdr_in_if
// Byte stream channel into the parser: valid/ready with one file byte.
// ----------------------------------------------------------------------------
interface wav_hdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, file_byte, start_of_file, end_of_file, input ready);
  modport sink   (input valid, file_byte, start_of_file, end_of_file, output ready);
endinterface

>>> design/wav_hdr_out_if.sv
// ----------------------------------------------------------------------------
// wav_hdr_out_if
// Result channel out of the parser: valid/ready with one format, data or
// error word.
// ----------------------------------------------------------------------------
interface wav_hdr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  format_code;
  logic [31:0] sample_rate;
  logic [31:0] data_length;
  logic [7:0]  audio_byte;
  logic        last_byte;
  logic [2:0]  error_code;

  modport source (output valid, kind, format_code, sample_rate, data_length,
                  audio_byte, last_byte, error_code, input ready);
  modport sink   (input valid, kind, format_code, sample_rate, data_length,
                  audio_byte, last_byte, error_code, output ready);
endinterface

>>> design/wav_hdr_in_reg.sv
// ----------------------------------------------------------------------------
// wav_hdr_in_reg
// Input register: holds one word until the parser core takes it.
// ----------------------------------------------------------------------------
module wav_hdr_in_reg
  import wav_hdr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  // accept a new word when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

>>> design/wav_hdr_core.sv
// ----------------------------------------------------------------------------
// wav_hdr_core
// Parser state machine: consumes one byte per fire and produces at most one
// result word.
// ----------------------------------------------------------------------------
module wav_hdr_core
  import wav_hdr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_word_t word_i,
  output res_t     res_o
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhRiff     = 4'd1;
  localparam logic [3:0] PhFmtHdr   = 4'd2;
  localparam logic [3:0] PhFmtBody  = 4'd3;
  localparam logic [3:0] PhFmtExtra = 4'd4;
  localparam logic [3:0] PhChunkId  = 4'd5;
  localparam logic [3:0] PhChunkSz  = 4'd6;
  localparam logic [3:0] PhSkip     = 4'd7;
  localparam logic [3:0] PhDataSz   = 4'd8;
  localparam logic [3:0] PhData     = 4'd9;
  localparam logic [3:0] PhDone     = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] fmt_size_q, fmt_size_d;
  logic        ch_ok_q, ch_ok_d;
  logic        stereo_q, stereo_d;
  logic        wide_q, wide_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] remain_q, remain_d;

  logic [3:0]  phase;
  logic [3:0]  pos;
  logic [31:0] shifted;
  logic [15:0] upper;
  logic [31:0] remain_dec;

  assign phase      = word_i.start_of_file ? PhRiff : phase_q;
  assign pos        = word_i.start_of_file ? 4'd0 : pos_q;
  assign shifted    = {word_i.file_byte, shift_q[31:8]};
  assign upper      = shifted[31:16];
  assign remain_dec = remain_q - 32'd1;

  always_comb begin
    phase_d    = phase;
    pos_d      = pos;
    shift_d    = shift_q;
    fmt_size_d = fmt_size_q;
    ch_ok_d    = ch_ok_q;
    stereo_d   = stereo_q;
    wide_d     = wide_q;
    rate_d     = rate_q;
    remain_d   = remain_q;
    res_o      = '0;

    if (phase == PhIdle || phase == PhDone) begin
      phase_d = phase;
    end else if (word_i.end_of_file) begin
      res_o.valid           = 1'b1;
      res_o.word.kind       = KIND_ERROR;
      phase_d               = PhDone;
      if (phase == PhData) begin
        res_o.word.error_code = ERR_TRUNC_DATA;
      end else if (phase == PhSkip || (phase == PhChunkId && pos == 4'd0)) begin
        res_o.word.error_code = ERR_NO_DATA;
      end else begin
        res_o.word.error_code = ERR_TRUNC_HDR;
      end
    end else begin
      pos_d = pos + 4'd1;
      case (phase)
        PhRiff: begin
          if (pos < 4'd4) shift_d = shifted;
          if (pos == 4'd11) begin
            if (shift_q != TagRiff) begin
              res_o.valid           = 1'b1;
              res_o.word.kind       = KIND_ERROR;
              res_o.word.error_code = ERR_BAD_RIFF;
              phase_d               = PhDone;
            end else begin
              phase_d = PhFmtHdr;
              pos_d   = 4'd0;
            end
          end
        end
        PhFmtHdr: begin
          if (pos < 4'd4) begin
            shift_d = shifted;
          end else begin
            fmt_size_d = {word_i.file_byte, fmt_size_q[31:8]};
          end
          if (pos == 4'd7) begin
            if (shift_q != TagFmt) begin
              res_o.valid           = 1'b1;
              res_o.word.kind       = KIND_ERROR;
              res_o.word.error_code = ERR_BAD_FMT;
              phase_d               = PhDone;
            end else begin
              phase_d = PhFmtBody;
              pos_d   = 4'd0;
            end
          end
        end
        PhFmtBody: begin
          shift_d = shifted;
          if (pos == 4'd1) begin
            if (upper != PcmTag) begin
              res_o.valid           = 1'b1;
              res_o.word.kind       = KIND_ERROR;
              res_o.word.error_code = ERR_NOT_PCM;
              phase_d               = PhDone;
            end
          end else if (pos == 4'd3) begin
            ch_ok_d  = (upper == 16'd1) || (upper == 16'd2);
            stereo_d = (upper == 16'd2);
          end else if (pos == 4'd7) begin
            rate_d = shifted;
          end else if (pos == 4'd15) begin
            wide_d = (upper == BitsWide);
            if (!((upper == BitsNarrow) || (upper == BitsWide)) || !ch_ok_q) begin
              res_o.valid           = 1'b1;
              res_o.word.kind       = KIND_ERROR;
              res_o.word.error_code = ERR_BAD_FORMAT;
              phase_d               = PhDone;
            end else if (fmt_size_q > FmtBase) begin
              remain_d = fmt_size_q - FmtBase;
              phase_d  = PhFmtExtra;
              pos_d    = 4'd0;
            end else begin
              phase_d = PhChunkId;
              pos_d   = 4'd0;
            end
          end
        end
        PhFmtExtra, PhSkip: begin
          remain_d = remain_dec;
          if (remain_q == 32'd1) begin
            phase_d = PhChunkId;
            pos_d   = 4'd0;
          end
        end
        PhChunkId: begin
          shift_d = shifted;
          if (pos == 4'd3) begin
            phase_d = (shifted == TagData) ? PhDataSz : PhChunkSz;
            pos_d   = 4'd0;
          end
        end
        PhChunkSz: begin
          shift_d = shifted;
          if (pos == 4'd3) begin
            remain_d = shifted;
            phase_d  = (shifted == 32'd0) ? PhChunkId : PhSkip;
            pos_d    = 4'd0;
          end
        end
        PhDataSz: begin
          shift_d = shifted;
          if (pos == 4'd3) begin
            remain_d               = shifted;
            res_o.valid            = 1'b1;
            res_o.word.kind        = KIND_FORMAT;
            res_o.word.format_code = {wide_q, stereo_q};
            res_o.word.sample_rate = rate_q;
            res_o.word.data_length = shifted;
            phase_d                = (shifted == 32'd0) ? PhDone : PhData;
            pos_d                  = 4'd0;
          end
        end
        PhData: begin
          remain_d              = remain_dec;
          res_o.valid           = 1'b1;
          res_o.word.kind       = KIND_DATA;
          res_o.word.audio_byte = word_i.file_byte;
          res_o.word.last_byte  = (remain_q == 32'd1);
          if (remain_q == 32'd1) begin
            phase_d = PhDone;
            pos_d   = 4'd0;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      pos_q      <= 4'd0;
      shift_q    <= '0;
      fmt_size_q <= '0;
      ch_ok_q    <= 1'b0;
      stereo_q   <= 1'b0;
      wide_q     <= 1'b0;
      rate_q     <= '0;
      remain_q   <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      fmt_size_q <= fmt_size_d;
      ch_ok_q    <= ch_ok_d;
      stereo_q   <= stereo_d;
      wide_q     <= wide_d;
      rate_q     <= rate_d;
      remain_q   <= remain_d;
    end
  end

endmodule

>>> design/wav_hdr_out_reg.sv
// ----------------------------------------------------------------------------
// wav_hdr_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module wav_hdr_out_reg
  import wav_hdr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_t      res_i,
  output logic      free_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_word_t word_o
);

  logic      valid_q;
  out_word_t word_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      word_q <= res_i.word;
    end
  end

endmodule

>>> design/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-serial RIFF/WAV PCM header parser with data byte pass-through.
//
//   channel   dir  words                    handshake
//   byte_i    in   file byte, sof, eof      valid/ready
//   result_o  out  format, data or error    valid/ready
//
// One byte per clock while result_o keeps taking results: input register,
// one combinational step of the parser state machine, result register.
// Reset leaves the parser waiting for a start-of-file byte.
// A stall on result_o holds the result register, then the input register;
// byte_i keeps accepting while either of them has room.
// ----------------------------------------------------------------------------
module wav_header_parser
  import wav_hdr_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  wav_hdr_in_if.sink   byte_i,
  wav_hdr_out_if.source result_o
);

  in_word_t  in_word;
  in_word_t  held_word;
  logic      held_valid;
  logic      out_free;
  logic      fire;
  res_t      res;
  out_word_t out_word;

  assign in_word.file_byte     = byte_i.file_byte;
  assign in_word.start_of_file = byte_i.start_of_file;
  assign in_word.end_of_file   = byte_i.end_of_file;

  // advance the parser only when the result register can take its output
  assign fire = held_valid && out_free;

  wav_hdr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .word_i  (in_word),
    .valid_o (held_valid),
    .take_i  (fire),
    .word_o  (held_word)
  );

  wav_hdr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (held_word),
    .res_o  (res)
  );

  wav_hdr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .word_o  (out_word)
  );

  assign result_o.kind        = out_word.kind;
  assign result_o.format_code = out_word.format_code;
  assign result_o.sample_rate = out_word.sample_rate;
  assign result_o.data_length = out_word.data_length;
  assign result_o.audio_byte  = out_word.audio_byte;
  assign result_o.last_byte   = out_word.last_byte;
  assign result_o.error_code  = out_word.error_code;

endmodule

>>> tb/sv/wav_parse_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_parse_check_pkg
// Result board for the WAV header parser testbench: a byte-level model of
// the parser that predicts each result word, and the check of every result
// word against the oldest prediction.
// ----------------------------------------------------------------------------
package wav_parse_check_pkg;
  import wav_hdr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_BODY,
    PH_FMT_EXTRA,
    PH_CHUNK_ID,
    PH_CHUNK_SIZE,
    PH_SKIP,
    PH_DATA_SIZE,
    PH_DATA,
    PH_DONE
  } parse_phase_e;

  class wav_parse_board;
    parse_phase_e phase;
    logic [31:0]  position;
    logic [31:0]  shift_reg;
    logic [31:0]  fmt_size;
    logic [31:0]  rate;
    logic [31:0]  remaining;
    logic [15:0]  chans;
    logic [15:0]  depth;
    out_word_t    expected_words[$];
    int           fail_count;
    int           files_seen;
    int           format_seen;
    int           data_seen;
    int           error_seen;
    logic [7:0]   codes_seen;

    function new();
      restart();
      fail_count  = 0;
      files_seen  = 0;
      format_seen = 0;
      data_seen   = 0;
      error_seen  = 0;
      codes_seen  = '0;
    endfunction

    function void restart();
      phase     = PH_IDLE;
      position  = '0;
      shift_reg = '0;
      fmt_size  = '0;
      rate      = '0;
      remaining = '0;
      chans     = '0;
      depth     = '0;
    endfunction

    function void enter(parse_phase_e next);
      phase    = next;
      position = '0;
    endfunction

    function void push_error(err_e code);
      out_word_t r;
      r = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      expected_words.push_back(r);
      phase = PH_DONE;
    endfunction

    // Advance the parse by one accepted byte word.
    function void predict_byte(in_word_t w);
      out_word_t   r;
      logic [31:0] pos;
      logic [31:0] shifted;
      r = '0;
      if (w.start_of_file) begin
        restart();
        phase = PH_RIFF;
        files_seen++;
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;

      if (w.end_of_file) begin
        if (phase == PH_DATA) begin
          push_error(ERR_TRUNC_DATA);
        end else if (phase == PH_SKIP || (phase == PH_CHUNK_ID && position == 0)) begin
          push_error(ERR_NO_DATA);
        end else begin
          push_error(ERR_TRUNC_HDR);
        end
        return;
      end

      pos      = position;
      position = position + 1;
      shifted  = {w.file_byte, shift_reg[31:8]};

      case (phase)
        PH_RIFF: begin
          if (pos < 4) shift_reg = shifted;
          if (pos == 11) begin
            if (shift_reg != TagRiff) push_error(ERR_BAD_RIFF);
            else enter(PH_FMT_HDR);
          end
        end
        PH_FMT_HDR: begin
          if (pos < 4) shift_reg = shifted;
          else fmt_size = {w.file_byte, fmt_size[31:8]};
          if (pos == 7) begin
            if (shift_reg != TagFmt) push_error(ERR_BAD_FMT);
            else enter(PH_FMT_BODY);
          end
        end
        PH_FMT_BODY: begin
          shift_reg = shifted;
          if (pos == 1) begin
            if (shift_reg[31:16] != PcmTag) push_error(ERR_NOT_PCM);
          end else if (pos == 3) begin
            chans = shift_reg[31:16];
          end else if (pos == 7) begin
            rate = shift_reg;
          end else if (pos == 15) begin
            depth = shift_reg[31:16];
            if ((depth != BitsNarrow && depth != BitsWide) ||
                (chans != 16'd1 && chans != 16'd2)) begin
              push_error(ERR_BAD_FORMAT);
            end else if (fmt_size > FmtBase) begin
              remaining = fmt_size - FmtBase;
              enter(PH_FMT_EXTRA);
            end else begin
              enter(PH_CHUNK_ID);
            end
          end
        end
        PH_FMT_EXTRA, PH_SKIP: begin
          remaining = remaining - 1;
          if (remaining == 0) enter(PH_CHUNK_ID);
        end
        PH_CHUNK_ID: begin
          shift_reg = shifted;
          if (pos == 3) begin
            if (shift_reg == TagData) enter(PH_DATA_SIZE);
            else enter(PH_CHUNK_SIZE);
          end
        end
        PH_CHUNK_SIZE: begin
          shift_reg = shifted;
          if (pos == 3) begin
            remaining = shift_reg;
            if (remaining == 0) enter(PH_CHUNK_ID);
            else enter(PH_SKIP);
          end
        end
        PH_DATA_SIZE: begin
          shift_reg = shifted;
          if (pos == 3) begin
            remaining         = shift_reg;
            r.kind            = KIND_FORMAT;
            r.format_code     = {depth == BitsWide, chans == 16'd2};
            r.sample_rate     = rate;
            r.data_length     = shift_reg;
            expected_words.push_back(r);
            if (remaining == 0) enter(PH_DONE);
            else enter(PH_DATA);
          end
        end
        PH_DATA: begin
          remaining    = remaining - 1;
          r.kind       = KIND_DATA;
          r.audio_byte = w.file_byte;
          r.last_byte  = (remaining == 0);
          expected_words.push_back(r);
          if (remaining == 0) enter(PH_DONE);
        end
        default: phase = PH_DONE;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word of kind %0d with nothing expected", got.kind);
        fail_count++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("format_code", 32'(want.format_code), 32'(got.format_code));
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
      compare_field("data_length", want.data_length, got.data_length);
      compare_field("audio_byte", 32'(want.audio_byte), 32'(got.audio_byte));
      compare_field("last_byte", 32'(want.last_byte), 32'(got.last_byte));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      case (want.kind)
        KIND_FORMAT: format_seen++;
        KIND_DATA:   data_seen++;
        default: begin
          error_seen++;
          codes_seen[want.error_code] = 1'b1;
        end
      endcase
    endfunction

    function void check_drained();
      if (expected_words.size() != 0) begin
        $error("%0d result words never arrived", expected_words.size());
        fail_count++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// WAV header parser testbench: feeds whole and broken WAV files one byte
// word at a time, predicts every format, data and error word, and checks
// the result stream under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import wav_hdr_pkg::*;
  import wav_parse_check_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ModeItems  = 40;
  localparam int ChunkCap   = 16;

  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] fmt_tag;
    logic [15:0] pcm;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [31:0] fmt_size;
    int          skip_chunks;
    logic [31:0] skip_size;
    logic [31:0] data_len;
    int          data_sent;
    int          cut;        // keep only this many bytes, -1 keeps all
    bit          end_mark;
  } wav_shape_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   file_items = 0;
  logic [7:0] file_bytes[$];

  wav_parse_board board = new();

  wav_hdr_in_if  byte_if();
  wav_hdr_out_if result_if();

  wav_header_parser dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check accepted result words, then pick the next ready.
  always @(posedge clk) begin : result_sink
    out_word_t got;
    if (rst_n && result_if.valid && result_if.ready) begin
      got.kind        = result_if.kind;
      got.format_code = result_if.format_code;
      got.sample_rate = result_if.sample_rate;
      got.data_length = result_if.data_length;
      got.audio_byte  = result_if.audio_byte;
      got.last_byte   = result_if.last_byte;
      got.error_code  = result_if.error_code;
      board.check_word(got);
    end
    result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic in_word_t make_word(logic [7:0] b, logic sof, logic eof);
    in_word_t w;
    w.file_byte     = b;
    w.start_of_file = sof;
    w.end_of_file   = eof;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid         <= 1'b1;
    byte_if.file_byte     <= w.file_byte;
    byte_if.start_of_file <= w.start_of_file;
    byte_if.end_of_file   <= w.end_of_file;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    board.predict_byte(w);
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic drain();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_rand(int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int capped(logic [31:0] n);
    return (n > ChunkCap) ? ChunkCap : int'(n);
  endfunction

  task automatic send_file(wav_shape_t s);
    logic [31:0] tag;
    file_bytes.delete();
    add_le(s.riff_tag, 4);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le(s.fmt_tag, 4);
    add_le(s.fmt_size, 4);
    add_le(32'(s.pcm), 2);
    add_le(32'(s.chans), 2);
    add_le(s.rate, 4);
    // byte rate and block align
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(32'(s.depth), 2);
    if (s.fmt_size > FmtBase) add_rand(capped(s.fmt_size - FmtBase));
    for (int k = 0; k < s.skip_chunks; k++) begin
      tag = $urandom;
      if (tag == TagData) tag[0] = ~tag[0];
      add_le(tag, 4);
      add_le(s.skip_size, 4);
      add_rand(capped(s.skip_size));
    end
    add_le(TagData, 4);
    add_le(s.data_len, 4);
    add_rand(s.data_sent);
    if (s.cut >= 0) begin
      while (file_bytes.size() > s.cut) void'(file_bytes.pop_back());
    end
    if (file_bytes.size() == 0) begin
      // empty file: start and end in one word
      send_word(make_word(8'($urandom_range(0, 255)), 1'b1, 1'b1));
      file_items++;
    end else begin
      foreach (file_bytes[i]) begin
        send_word(make_word(file_bytes[i], i == 0, 1'b0));
        file_items++;
      end
      if (s.end_mark) begin
        send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        file_items++;
      end
    end
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) begin
      send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
    end
  endtask

  function automatic wav_shape_t good_shape();
    wav_shape_t s;
    s.riff_tag    = TagRiff;
    s.fmt_tag     = TagFmt;
    s.pcm         = PcmTag;
    s.chans       = 16'd1;
    s.depth       = BitsNarrow;
    s.rate        = 32'd8000;
    s.fmt_size    = FmtBase;
    s.skip_chunks = 0;
    s.skip_size   = '0;
    s.data_len    = 32'd4;
    s.data_sent   = 4;
    s.cut         = -1;
    s.end_mark    = 1'b1;
    return s;
  endfunction

  function automatic wav_shape_t rand_shape();
    wav_shape_t s;
    int pick;
    s = good_shape();
    if ($urandom_range(0, 99) < 4) s.riff_tag = $urandom;
    if ($urandom_range(0, 99) < 4) s.fmt_tag = $urandom;
    if ($urandom_range(0, 99) < 4) s.pcm = 16'($urandom_range(0, 65535));
    s.chans = 16'($urandom_range(1, 2));
    if ($urandom_range(0, 99) < 8) s.chans = 16'($urandom_range(0, 65535));
    s.depth = $urandom_range(0, 1) ? BitsWide : BitsNarrow;
    if ($urandom_range(0, 99) < 8) s.depth = 16'($urandom_range(0, 65535));
    s.rate = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 12) s.fmt_size = FmtBase;
    else if (pick < 16) s.fmt_size = $urandom_range(0, 15);
    else if (pick < 19) s.fmt_size = $urandom_range(17, 28);
    else s.fmt_size = $urandom;
    s.skip_chunks = $urandom_range(0, 2);
    s.skip_size = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 9));
    if ($urandom_range(0, 9) == 0) begin
      s.data_len  = $urandom;
      s.data_sent = $urandom_range(0, 8);
    end else begin
      s.data_len  = $urandom_range(0, 24);
      s.data_sent = int'(s.data_len);
    end
    s.cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : -1;
    s.end_mark = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic run_directed();
    wav_shape_t s;
    send_noise(3);                                  // idle parser ignores these
    s = good_shape(); s.cut = 0;                    send_file(s);
    // broken files stop right after the byte that ends the parse
    s = good_shape(); s.riff_tag = 32'h5846_4952; s.cut = 12; send_file(s);
    s = good_shape(); s.fmt_tag = 32'h2074_6D67; s.cut = 20;  send_file(s);
    s = good_shape(); s.pcm = 16'd3; s.cut = 22;              send_file(s);
    s = good_shape(); s.chans = 16'd3; s.cut = 36;            send_file(s);
    s = good_shape(); s.fmt_size = '0; s.data_len = '0; s.data_sent = 0;
    send_file(s);
    send_noise(2);                                  // finished parser ignores these
    s = good_shape(); s.cut = 36;                   send_file(s);
    s = good_shape(); s.data_len = 32'hFFFF_FFFF; s.data_sent = 1;
    send_file(s);
    // restart in the middle of a header
    s = good_shape(); s.cut = 30; s.end_mark = 1'b0; send_file(s);
    s = good_shape(); s.depth = 16'd24; s.cut = 36;  send_file(s);
  endtask

  initial begin
    byte_if.valid         <= 1'b0;
    byte_if.file_byte     <= '0;
    byte_if.start_of_file <= 1'b0;
    byte_if.end_of_file   <= 1'b0;
    rst_n                 <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      file_items = 0;
      while (file_items < ModeItems) begin
        if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4));
        send_file(rand_shape());
      end
      drain();
    end

    byte_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    board.check_drained();

    $display("covered %0d files: %0d format, %0d data and %0d error words checked",
             board.files_seen, board.format_seen, board.data_seen, board.error_seen);
    $display("error codes seen (bit per code): %b", board.codes_seen[6:0]);
    if (board.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> wav_header_parser.f
design/wav_hdr_pkg.sv
design/wav_hdr_in_if.sv
design/wav_hdr_out_if.sv
design/wav_hdr_in_reg.sv
design/wav_hdr_core.sv
design/wav_hdr_out_reg.sv
design/wav_header_parser.sv
tb/sv/wav_parse_check_pkg.sv
tb/sv/tb_top.sv
